/* hdl/flc_pkg.sv */
// Shared types and constants for the full linear convolution engine.
package flc_pkg;

    // Fixed field widths
    localparam int VALUE_W    = 16;
    localparam int TAP_IDX_W  = 4;
    localparam int TAP_CNT_W  = 5;
    localparam int PROD_W     = 2 * VALUE_W;
    localparam int SUM_W      = 36;

    // Input mode codes
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = QPTR_W + 1;

    // Classified operation carried through the queue
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_SAMPLE,
        OP_SAMPLE_EOS
    } flc_op_t;

    typedef struct packed {
        flc_op_t                op;
        logic [TAP_IDX_W-1:0]   tap_index;
        logic [VALUE_W-1:0]     value;
    } flc_entry_t;

endpackage

/* hdl/flc_front.sv */
// Front end: accepts input words, classifies them and pushes them into the queue.
module flc_front #(
    parameter int MAX_TAPS = 16
) (
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_mode,
    input  logic [flc_pkg::TAP_IDX_W-1:0]      s_tap_index,
    input  logic signed [flc_pkg::VALUE_W-1:0] s_value,
    input  logic                               s_end_of_sequence,
    input  logic                               q_full,
    output logic                               q_push,
    output flc_pkg::flc_entry_t                q_entry
);

    logic accept;
    logic keep;

    // Take a word whenever the queue has room
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Classify the word; drop loads aimed past the last coefficient
    always_comb begin
        q_entry.tap_index = s_tap_index;
        q_entry.value     = s_value;
        keep              = 1'b1;
        priority if (s_mode == flc_pkg::MODE_LOAD) begin
            q_entry.op = flc_pkg::OP_LOAD;
            keep       = (int'(s_tap_index) < MAX_TAPS);
        end else if (s_end_of_sequence) begin
            q_entry.op = flc_pkg::OP_SAMPLE_EOS;
        end else begin
            q_entry.op = flc_pkg::OP_SAMPLE;
        end
    end

    assign q_push = accept && keep;

endmodule

/* hdl/flc_queue.sv */
// Short FIFO that decouples the front end from the filter back end.
module flc_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  flc_pkg::flc_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output flc_pkg::flc_entry_t head
);

    flc_pkg::flc_entry_t              slot_reg [flc_pkg::QUEUE_DEPTH];
    logic [flc_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [flc_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [flc_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                             do_push, do_pop;

    assign full      = (count_reg == flc_pkg::QCNT_W'(flc_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && not_empty;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* hdl/flc_back.sv */
// Back end: coefficient store, sample history, tap multipliers and registered adder tree.
module flc_back #(
    parameter int MAX_TAPS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [flc_pkg::TAP_CNT_W-1:0]     tap_count,
    input  logic                              q_valid,
    input  flc_pkg::flc_entry_t               q_entry,
    output logic                              q_pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [flc_pkg::SUM_W-1:0]  m_sum,
    output logic                              m_last_of_run
);

    localparam int CNT_W  = ($clog2(MAX_TAPS + 1) > flc_pkg::TAP_CNT_W) ?
                            $clog2(MAX_TAPS + 1) : flc_pkg::TAP_CNT_W;
    localparam int LEVELS = $clog2(MAX_TAPS);
    localparam int P2     = 1 << LEVELS;
    localparam int HIST_N = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;

    logic signed [flc_pkg::VALUE_W-1:0] coef_reg [MAX_TAPS];
    logic signed [flc_pkg::VALUE_W-1:0] hist_reg [HIST_N];
    logic signed [flc_pkg::SUM_W-1:0]   node_reg [1:2*P2-1];
    logic [LEVELS:0]                    vld_reg;
    logic [LEVELS:0]                    last_reg;
    logic [CNT_W-1:0]                   tail_left_reg, tail_left_next;

    logic [CNT_W-1:0]                   tc, taps;
    logic                               pipe_en, tail_active;
    logic                               is_load, is_sample, eos;
    logic                               exec, exec_last;
    logic signed [flc_pkg::VALUE_W-1:0] exec_x;

    // Clamp the tap count into 1..MAX_TAPS
    always_comb begin
        tc = CNT_W'(tap_count);
        if (tc == '0) begin
            taps = CNT_W'(1);
        end else if (tc > CNT_W'(MAX_TAPS)) begin
            taps = CNT_W'(MAX_TAPS);
        end else begin
            taps = tc;
        end
    end

    // Whole pipe advances unless a finished word is held at the output
    assign pipe_en     = !vld_reg[LEVELS] || m_ready;
    assign tail_active = (tail_left_reg != '0);
    assign q_pop       = pipe_en && !tail_active && q_valid;
    assign eos         = (q_entry.op == flc_pkg::OP_SAMPLE_EOS);
    assign is_load     = q_pop && (q_entry.op == flc_pkg::OP_LOAD);
    assign is_sample   = q_pop && ((q_entry.op == flc_pkg::OP_SAMPLE) || eos);
    assign exec        = (pipe_en && tail_active) || is_sample;
    assign exec_x      = tail_active ? '0 : $signed(q_entry.value);
    assign exec_last   = tail_active ? (tail_left_reg == CNT_W'(1))
                                     : (eos && (taps == CNT_W'(1)));

    // Count down the zero-input tail after a marked sample
    always_comb begin
        tail_left_next = tail_left_reg;
        if (pipe_en && tail_active) begin
            tail_left_next = tail_left_reg - 1'b1;
        end else if (is_sample && eos && (taps != CNT_W'(1))) begin
            tail_left_next = taps - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tail_left_reg <= '0;
        end else begin
            tail_left_reg <= tail_left_next;
        end
    end

    // Coefficient store, written by load words
    for (genvar i = 0; i < MAX_TAPS; i++) begin : g_coef
        always_ff @(posedge aclk) begin
            if (is_load && (int'(q_entry.tap_index) == i)) begin
                coef_reg[i] <= $signed(q_entry.value);
            end
        end
    end

    // Sample history: shift on each step, clear on the last step of a run
    for (genvar j = 0; j < HIST_N; j++) begin : g_hist
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                hist_reg[j] <= '0;
            end else if (exec) begin
                if (exec_last) begin
                    hist_reg[j] <= '0;
                end else if (j == 0) begin
                    hist_reg[j] <= exec_x;
                end else begin
                    hist_reg[j] <= hist_reg[(j > 0) ? j - 1 : 0];
                end
            end
        end
    end

    // Tap lanes: one multiplier each, products land in the tree leaves
    for (genvar i = 0; i < P2; i++) begin : g_lane
        if (i < MAX_TAPS) begin : g_used
            logic signed [flc_pkg::VALUE_W-1:0] opnd;
            logic signed [flc_pkg::PROD_W-1:0]  prod;
            logic                               lane_on;

            if (i == 0) begin : g_first
                assign opnd = exec_x;
            end else begin : g_rest
                assign opnd = hist_reg[(i > 0) ? i - 1 : 0];
            end

            assign lane_on = (int'(taps) > i);
            assign prod    = coef_reg[i] * opnd;

            always_ff @(posedge aclk) begin
                if (pipe_en) begin
                    node_reg[P2+i] <= lane_on ?
                        {{(flc_pkg::SUM_W-flc_pkg::PROD_W){prod[flc_pkg::PROD_W-1]}}, prod}
                        : '0;
                end
            end
        end else begin : g_pad
            always_ff @(posedge aclk) begin
                if (pipe_en) begin
                    node_reg[P2+i] <= '0;
                end
            end
        end
    end

    // Registered adder tree, one register per add level
    for (genvar k = 1; k < P2; k++) begin : g_tree
        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                node_reg[k] <= node_reg[2*k] + node_reg[2*k+1];
            end
        end
    end

    // Valid and last flags travel alongside the tree
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            last_reg <= '0;
        end else if (pipe_en) begin
            vld_reg  <= (LEVELS + 1)'({vld_reg, exec});
            last_reg <= (LEVELS + 1)'({last_reg, exec_last});
        end
    end

    assign m_valid       = vld_reg[LEVELS];
    assign m_sum         = node_reg[1];
    assign m_last_of_run = last_reg[LEVELS];

endmodule

/* hdl/full_linear_convolution.sv */
// Top level of the streaming full linear convolution engine.
//
// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      mode, tap_index, value, end_of_sequence
// m_        out        m_valid / m_ready      sum, last_of_run
// cfg_      in         cfg_valid / cfg_ready  tap_count
//
// One input word is taken per cycle while the queue is not full; after a marked sample
// the back end runs tap_count-1 zero-input tail steps while the queue holds new words.
// A sample's sum passes the lane registers, then one register per adder-tree level.
// Reset clears the queue, pipeline flags, tail counter and sample history and sets
// tap_count to 1; coefficients hold nothing until loaded.
// A stalled m_ready freezes the whole back end; the four-word queue takes input until full.
module full_linear_convolution #(
    parameter int MAX_TAPS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_mode,
    input  logic [flc_pkg::TAP_IDX_W-1:0]      s_tap_index,
    input  logic signed [flc_pkg::VALUE_W-1:0] s_value,
    input  logic                               s_end_of_sequence,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [flc_pkg::SUM_W-1:0]   m_sum,
    output logic                               m_last_of_run,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [flc_pkg::TAP_CNT_W-1:0]      cfg_tap_count
);

    logic [flc_pkg::TAP_CNT_W-1:0] tap_count_reg;
    logic                          q_push, q_full, q_pop, q_not_empty;
    flc_pkg::flc_entry_t           push_entry, head_entry;

    // Hold the tap count register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg <= flc_pkg::TAP_CNT_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            tap_count_reg <= cfg_tap_count;
        end
    end

    flc_front #(
        .MAX_TAPS (MAX_TAPS)
    ) u_front (
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_tap_index       (s_tap_index),
        .s_value           (s_value),
        .s_end_of_sequence (s_end_of_sequence),
        .q_full            (q_full),
        .q_push            (q_push),
        .q_entry           (push_entry)
    );

    flc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (head_entry)
    );

    flc_back #(
        .MAX_TAPS (MAX_TAPS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tap_count     (tap_count_reg),
        .q_valid       (q_not_empty),
        .q_entry       (head_entry),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sum         (m_sum),
        .m_last_of_run (m_last_of_run)
    );

endmodule
